// ===== hw/rtl/tst_pkg.sv =====
// Shared types, constants and sizes of the translator session table.
`timescale 1ns / 1ps

package tst_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = SLOT_W;
    localparam int EXP_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [2:0] MODE_FIND6   = 3'd0;
    localparam logic [2:0] MODE_FIND4   = 3'd1;
    localparam logic [2:0] MODE_INSERT  = 3'd2;
    localparam logic [2:0] MODE_REFRESH = 3'd3;
    localparam logic [2:0] MODE_TICK    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NF     = 2'd1;
    localparam logic [1:0] ST_NOADDR = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL    = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] ipv6_high;
        logic [63:0] ipv6_low;
        logic [31:0] ipv4_query;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      mapped_ipv4;
        logic [63:0]      found_ipv6_high;
        logic [63:0]      found_ipv6_low;
        logic [EXP_W-1:0] expired_count;
    } t_res;

    typedef struct packed {
        logic        valid;
        logic [15:0] ttl;
        logic [31:0] ipv4;
        logic [63:0] ipv6_high;
        logic [63:0] ipv6_low;
    } t_entry;

    typedef enum logic [1:0] {
        KEY_V6,
        KEY_V4Q,
        KEY_CAND
    } t_key_src;

    typedef enum logic [2:0] {
        RC_FOUND,
        RC_NEW,
        RC_NF,
        RC_NOADDR,
        RC_FULL,
        RC_TICK
    } t_res_code;

    typedef struct packed {
        logic      load_req;
        logic      div_start;
        t_key_src  div_src;
        logic      idx_clr;
        logic      idx_inc;
        logic      idx_key;
        logic      idx_step;
        logic      use_v4;
        logic      slot_rd;
        logic      slot_zero;
        logic      clr_all;
        logic      ent_rd_idx;
        logic      ent_rd_slot;
        logic      ent_age;
        logic      ent_refresh;
        logic      ent_commit;
        logic      bm_clr;
        logic      bm_fill;
        logic      bm_rd;
        logic      off_clr;
        logic      off_inc;
        logic      free_clr;
        logic      free_upd;
        logic      exp_clr;
        logic      latch_s4;
        logic      latch_s6;
        logic      res_load;
        t_res_code res_code;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       cnt_full;
        logic       slot_hit;
        logic       slot_empty;
        logic       ent_match;
        logic       ent_valid;
        logic       idx_last;
        logic       off_end;
        logic       bm_bit;
        logic       cand_over;
        logic       free_found;
        logic [2:0] mode;
    } t_sts;

endpackage

// ===== hw/rtl/tst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tst_rem.sv =====
// Bit-serial remainder unit: 32-bit value modulo the pool size.
`timescale 1ns / 1ps

module tst_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_num,
    input  logic [tst_pkg::CNT_W-1:0]  i_den,
    output logic                       o_done,
    output logic [tst_pkg::ADDR_W-1:0] o_rem
);

    logic                      r_busy;
    logic                      r_done;
    logic [4:0]                r_step;
    logic [31:0]               r_num;
    logic [tst_pkg::CNT_W-1:0] r_rem;
    logic [tst_pkg::CNT_W:0]   trial;
    logic [tst_pkg::CNT_W:0]   diff;

    assign trial = {r_rem, r_num[31]};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                // restoring step: one dividend bit per cycle
                if (trial >= {1'b0, i_den}) begin
                    r_rem <= diff[tst_pkg::CNT_W-1:0];
                end else begin
                    r_rem <= trial[tst_pkg::CNT_W-1:0];
                end
                r_num  <= {r_num[30:0], 1'b0};
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[tst_pkg::ADDR_W-1:0];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_den))
        else $error("remainder not below divisor");

endmodule

// ===== hw/rtl/tst_dp.sv =====
// Datapath: config registers, slot tables, entry store, address bitmap, key unit.
`timescale 1ns / 1ps

module tst_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tst_pkg::t_req                     i_req,
    input  tst_pkg::t_cmd                     i_cmd,
    output tst_pkg::t_sts                     o_sts,
    output tst_pkg::t_res                     o_res
);

    localparam int ENT_W = $bits(tst_pkg::t_entry);

    function automatic logic [31:0] swap32(input logic [31:0] x);
        swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // configuration
    logic [31:0] r_net;
    logic [4:0]  r_prefix;
    logic [15:0] r_ttl;

    tst_pkg::t_req r_req;
    tst_pkg::t_res r_res;
    tst_pkg::t_res n_res;

    logic [tst_pkg::ADDR_W-1:0]  r_idx;
    logic [tst_pkg::CNT_W-1:0]   r_cnt;
    logic [tst_pkg::CNT_W-1:0]   r_off;
    logic [tst_pkg::ADDR_W-1:0]  r_ent_idx;
    logic                        r_free_found;
    logic [tst_pkg::ADDR_W-1:0]  r_s4;
    logic [tst_pkg::ADDR_W-1:0]  r_s6;
    logic [tst_pkg::EXP_W-1:0]   r_exp;

    logic [31:0]                 host_mask;
    logic [31:0]                 bcast;
    logic [tst_pkg::CNT_W-1:0]   pool;
    logic [32:0]                 cand;
    logic [31:0]                 div_num;
    logic                        div_done;
    logic [tst_pkg::ADDR_W-1:0]  div_rem;
    logic [tst_pkg::CNT_W-1:0]   idx_next;

    logic [tst_pkg::SLOT_W-1:0]  v4_rdata;
    logic [tst_pkg::SLOT_W-1:0]  v6_rdata;
    logic [tst_pkg::SLOT_W-1:0]  slot_q;
    logic [tst_pkg::SLOT_W-1:0]  slot_m1;
    logic [tst_pkg::ADDR_W-1:0]  slot_addr;
    logic                        v4_we;
    logic                        v6_we;
    logic [tst_pkg::ADDR_W-1:0]  v4_waddr;
    logic [tst_pkg::ADDR_W-1:0]  v6_waddr;
    logic [tst_pkg::SLOT_W-1:0]  slot_wdata;

    tst_pkg::t_entry             ent_rd;
    logic [ENT_W-1:0]            ent_rdata;
    tst_pkg::t_entry             ent_wd;
    logic                        ent_we;
    logic [tst_pkg::ADDR_W-1:0]  ent_waddr;
    logic [tst_pkg::ADDR_W-1:0]  ent_raddr;
    logic [15:0]                 aged_ttl;

    logic                        bm_we;
    logic [tst_pkg::ADDR_W-1:0]  bm_waddr;
    logic                        bm_wdata;
    logic                        bm_rdata;
    logic [31:0]                 bm_off;
    logic                        bm_take;

    // pool geometry
    assign host_mask = 32'hFFFF_FFFF >> r_prefix;
    assign bcast     = r_net | host_mask;
    assign pool      = (host_mask > 32'(tst_pkg::TABLE_DEPTH)) ?
                       tst_pkg::CNT_W'(tst_pkg::TABLE_DEPTH) :
                       host_mask[tst_pkg::CNT_W-1:0];
    assign cand      = {1'b0, r_net} + 33'd1 + 33'(r_off);

    always_comb begin
        case (i_cmd.div_src)
            tst_pkg::KEY_V4Q:  div_num = swap32(r_req.ipv4_query);
            tst_pkg::KEY_CAND: div_num = swap32(cand[31:0]);
            default: div_num = swap32(r_req.ipv6_high[63:32]) + swap32(r_req.ipv6_high[31:0])
                             + swap32(r_req.ipv6_low[63:32]) + swap32(r_req.ipv6_low[31:0]);
        endcase
    end

    tst_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (pool),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // slot tables
    assign slot_q     = i_cmd.use_v4 ? v4_rdata : v6_rdata;
    assign slot_m1    = slot_q - tst_pkg::SLOT_W'(1);
    assign slot_addr  = slot_m1[tst_pkg::ADDR_W-1:0];
    assign slot_wdata = i_cmd.ent_commit ?
                        (tst_pkg::SLOT_W'(r_ent_idx) + tst_pkg::SLOT_W'(1)) : '0;
    assign v4_we      = i_cmd.clr_all || i_cmd.ent_commit || (i_cmd.slot_zero && i_cmd.use_v4);
    assign v6_we      = i_cmd.clr_all || i_cmd.ent_commit || (i_cmd.slot_zero && !i_cmd.use_v4);
    assign v4_waddr   = i_cmd.ent_commit ? r_s4 : r_idx;
    assign v6_waddr   = i_cmd.ent_commit ? r_s6 : r_idx;

    tst_ram #(.WIDTH(tst_pkg::SLOT_W), .DEPTH(tst_pkg::TABLE_DEPTH)) u_v4_slots (
        .i_clk   (i_clk),
        .i_we    (v4_we),
        .i_waddr (v4_waddr),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.slot_rd && i_cmd.use_v4),
        .i_raddr (r_idx),
        .o_rdata (v4_rdata)
    );

    tst_ram #(.WIDTH(tst_pkg::SLOT_W), .DEPTH(tst_pkg::TABLE_DEPTH)) u_v6_slots (
        .i_clk   (i_clk),
        .i_we    (v6_we),
        .i_waddr (v6_waddr),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.slot_rd && !i_cmd.use_v4),
        .i_raddr (r_idx),
        .o_rdata (v6_rdata)
    );

    // entry store
    assign ent_rd    = tst_pkg::t_entry'(ent_rdata);
    assign ent_raddr = i_cmd.ent_rd_slot ? slot_addr : r_idx;
    assign aged_ttl  = (ent_rd.ttl != 16'd0) ? (ent_rd.ttl - 16'd1) : 16'd0;

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = r_idx;
        ent_wd    = '0;
        if (i_cmd.clr_all) begin
            ent_we = 1'b1;
        end else if (i_cmd.ent_age && ent_rd.valid) begin
            ent_we       = 1'b1;
            ent_wd       = ent_rd;
            ent_wd.ttl   = aged_ttl;
            ent_wd.valid = (aged_ttl != 16'd0);
        end else if (i_cmd.ent_refresh) begin
            ent_we     = 1'b1;
            ent_waddr  = slot_addr;
            ent_wd     = ent_rd;
            ent_wd.ttl = r_ttl;
        end else if (i_cmd.ent_commit) begin
            ent_we           = 1'b1;
            ent_waddr        = r_ent_idx;
            ent_wd.valid     = 1'b1;
            ent_wd.ttl       = r_ttl;
            ent_wd.ipv4      = cand[31:0];
            ent_wd.ipv6_high = r_req.ipv6_high;
            ent_wd.ipv6_low  = r_req.ipv6_low;
        end
    end

    tst_ram #(.WIDTH(ENT_W), .DEPTH(tst_pkg::TABLE_DEPTH)) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ENT_W'(ent_wd)),
        .i_re    (i_cmd.ent_rd_idx || i_cmd.ent_rd_slot),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // taken-address bitmap, rebuilt on every insert
    assign bm_off   = ent_rd.ipv4 - r_net - 32'd1;
    assign bm_take  = ent_rd.valid && (ent_rd.ipv4 > r_net) &&
                      (bm_off < 32'(tst_pkg::TABLE_DEPTH));
    assign bm_we    = i_cmd.bm_clr || (i_cmd.bm_fill && bm_take);
    assign bm_waddr = i_cmd.bm_clr ? r_idx : bm_off[tst_pkg::ADDR_W-1:0];
    assign bm_wdata = !i_cmd.bm_clr;

    tst_ram #(.WIDTH(1), .DEPTH(tst_pkg::TABLE_DEPTH)) u_taken (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (i_cmd.bm_rd),
        .i_raddr (r_off[tst_pkg::ADDR_W-1:0]),
        .o_rdata (bm_rdata)
    );

    assign idx_next = tst_pkg::CNT_W'(r_idx) + tst_pkg::CNT_W'(1);

    // result word for the code the controller hands over
    always_comb begin
        n_res = '0;
        case (i_cmd.res_code)
            tst_pkg::RC_FOUND: begin
                n_res.status          = tst_pkg::ST_OK;
                n_res.mapped_ipv4     = ent_rd.ipv4;
                n_res.found_ipv6_high = ent_rd.ipv6_high;
                n_res.found_ipv6_low  = ent_rd.ipv6_low;
            end
            tst_pkg::RC_NEW: begin
                n_res.status          = tst_pkg::ST_OK;
                n_res.mapped_ipv4     = cand[31:0];
                n_res.found_ipv6_high = r_req.ipv6_high;
                n_res.found_ipv6_low  = r_req.ipv6_low;
            end
            tst_pkg::RC_TICK: begin
                n_res.status        = tst_pkg::ST_OK;
                n_res.expired_count = r_exp;
            end
            tst_pkg::RC_NOADDR: n_res.status = tst_pkg::ST_NOADDR;
            tst_pkg::RC_FULL:   n_res.status = tst_pkg::ST_FULL;
            default:            n_res.status = tst_pkg::ST_NF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net        <= '0;
            r_prefix     <= 5'd24;
            r_ttl        <= 16'd60;
            r_idx        <= '0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tst_pkg::CFG_NET:    r_net    <= i_cfg_data;
                    tst_pkg::CFG_PREFIX: r_prefix <= i_cfg_data[4:0];
                    tst_pkg::CFG_TTL:    r_ttl    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + tst_pkg::ADDR_W'(1);
            end else if (i_cmd.idx_key) begin
                r_idx <= div_rem;
            end else if (i_cmd.idx_step) begin
                r_idx <= (idx_next >= pool) ? '0 : idx_next[tst_pkg::ADDR_W-1:0];
            end
            if (i_cmd.free_clr) begin
                r_free_found <= 1'b0;
            end else if (i_cmd.free_upd && !r_free_found && !ent_rd.valid) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.idx_key) begin
            r_cnt <= '0;
        end else if (i_cmd.idx_step) begin
            r_cnt <= r_cnt + tst_pkg::CNT_W'(1);
        end
        if (i_cmd.off_clr) begin
            r_off <= '0;
        end else if (i_cmd.off_inc) begin
            r_off <= r_off + tst_pkg::CNT_W'(1);
        end
        if (i_cmd.free_upd && !r_free_found && !ent_rd.valid) begin
            r_ent_idx <= r_idx;
        end
        if (i_cmd.latch_s4) begin
            r_s4 <= r_idx;
        end
        if (i_cmd.latch_s6) begin
            r_s6 <= r_idx;
        end
        if (i_cmd.exp_clr) begin
            r_exp <= '0;
        end else if (i_cmd.ent_age && ent_rd.valid && aged_ttl == 16'd0) begin
            r_exp <= r_exp + tst_pkg::EXP_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.div_done   = div_done;
        o_sts.cnt_full   = (r_cnt == pool);
        o_sts.slot_hit   = (slot_q != '0) &&
                           (slot_q <= tst_pkg::SLOT_W'(tst_pkg::TABLE_DEPTH));
        o_sts.slot_empty = (slot_q == '0);
        o_sts.ent_valid  = ent_rd.valid;
        o_sts.ent_match  = ent_rd.valid && (i_cmd.use_v4 ?
                           (ent_rd.ipv4 == r_req.ipv4_query) :
                           (ent_rd.ipv6_high == r_req.ipv6_high &&
                            ent_rd.ipv6_low == r_req.ipv6_low));
        o_sts.idx_last   = (r_idx == tst_pkg::ADDR_W'(tst_pkg::TABLE_DEPTH - 1));
        o_sts.off_end    = (r_off == tst_pkg::CNT_W'(tst_pkg::TABLE_DEPTH));
        o_sts.bm_bit     = bm_rdata;
        o_sts.cand_over  = (cand >= {1'b0, bcast});
        o_sts.free_found = r_free_found;
        o_sts.mode       = r_req.mode;
    end

    assign o_res = r_res;

    a_ent_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_all, i_cmd.ent_age, i_cmd.ent_refresh, i_cmd.ent_commit}))
        else $error("conflicting entry store writes");

endmodule

// ===== hw/rtl/tst_ctrl.sv =====
// Controller: sequences clearing, lookups, inserts and aging over the datapath.
`timescale 1ns / 1ps

module tst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output tst_pkg::t_cmd o_cmd,
    input  tst_pkg::t_sts i_sts
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_KEY,
        S_P_SLOT,
        S_P_WAIT,
        S_P_ENT,
        S_BM_CLR,
        S_FILL_RD,
        S_FILL_CK,
        S_SCAN_RD,
        S_SCAN_CK,
        S_CAND,
        S_E_SLOT,
        S_E_WAIT,
        S_COMMIT,
        S_AGE_RD,
        S_AGE_CK,
        S_SW_RD,
        S_SW_SLOT,
        S_SW_ENT,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic                r_v4, n_v4;
    logic                r_ins, n_ins;
    logic                r_refresh, n_refresh;
    tst_pkg::t_res_code  r_code, n_code;
    logic                r_res_valid;

    always_comb begin
        n_state   = r_state;
        n_v4      = r_v4;
        n_ins     = r_ins;
        n_refresh = r_refresh;
        n_code    = r_code;
        o_cmd     = '0;
        o_cmd.use_v4   = r_v4;
        o_cmd.res_code = r_code;
        o_cmd.div_src  = tst_pkg::KEY_V6;

        unique case (r_state) inside
            S_CLEAR: begin
                o_cmd.clr_all = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.free_clr = 1'b1;
                o_cmd.exp_clr  = 1'b1;
                n_ins     = 1'b0;
                n_refresh = 1'b0;
                unique case (i_sts.mode) inside
                    tst_pkg::MODE_FIND6, tst_pkg::MODE_REFRESH: begin
                        o_cmd.div_start = 1'b1;
                        n_v4      = 1'b0;
                        n_refresh = (i_sts.mode == tst_pkg::MODE_REFRESH);
                        n_state   = S_KEY;
                    end
                    tst_pkg::MODE_FIND4: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_src   = tst_pkg::KEY_V4Q;
                        n_v4    = 1'b1;
                        n_state = S_KEY;
                    end
                    tst_pkg::MODE_INSERT: begin
                        n_ins   = 1'b1;
                        n_state = S_BM_CLR;
                    end
                    tst_pkg::MODE_TICK: begin
                        n_state = S_AGE_RD;
                    end
                    default: begin
                        n_code  = tst_pkg::RC_NF;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_KEY: begin
                if (i_sts.div_done) begin
                    o_cmd.idx_key = 1'b1;
                    n_state = r_ins ? S_E_SLOT : S_P_SLOT;
                end
            end
            S_P_SLOT: begin
                if (i_sts.cnt_full) begin
                    n_code  = tst_pkg::RC_NF;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.slot_rd = 1'b1;
                    n_state = S_P_WAIT;
                end
            end
            S_P_WAIT: begin
                if (i_sts.slot_hit) begin
                    o_cmd.ent_rd_slot = 1'b1;
                    n_state = S_P_ENT;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state = S_P_SLOT;
                end
            end
            S_P_ENT: begin
                if (i_sts.ent_match) begin
                    o_cmd.ent_refresh = r_refresh;
                    n_code  = tst_pkg::RC_FOUND;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state = S_P_SLOT;
                end
            end
            S_BM_CLR: begin
                o_cmd.bm_clr = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_FILL_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_FILL_RD: begin
                o_cmd.ent_rd_idx = 1'b1;
                n_state = S_FILL_CK;
            end
            S_FILL_CK: begin
                o_cmd.bm_fill  = 1'b1;
                o_cmd.free_upd = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.off_clr = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_FILL_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.off_end) begin
                    n_state = S_CAND;
                end else begin
                    o_cmd.bm_rd = 1'b1;
                    n_state = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (i_sts.bm_bit) begin
                    o_cmd.off_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                if (i_sts.cand_over) begin
                    n_code  = tst_pkg::RC_NOADDR;
                    n_state = S_FINISH;
                end else if (!i_sts.free_found) begin
                    n_code  = tst_pkg::RC_FULL;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = tst_pkg::KEY_CAND;
                    n_v4    = 1'b1;
                    n_state = S_KEY;
                end
            end
            S_E_SLOT: begin
                if (i_sts.cnt_full) begin
                    n_code  = tst_pkg::RC_FULL;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.slot_rd = 1'b1;
                    n_state = S_E_WAIT;
                end
            end
            S_E_WAIT: begin
                if (i_sts.slot_empty) begin
                    if (r_v4) begin
                        o_cmd.latch_s4  = 1'b1;
                        o_cmd.div_start = 1'b1;
                        n_v4    = 1'b0;
                        n_state = S_KEY;
                    end else begin
                        o_cmd.latch_s6 = 1'b1;
                        n_state = S_COMMIT;
                    end
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state = S_E_SLOT;
                end
            end
            S_COMMIT: begin
                o_cmd.ent_commit = 1'b1;
                n_code  = tst_pkg::RC_NEW;
                n_state = S_FINISH;
            end
            S_AGE_RD: begin
                o_cmd.ent_rd_idx = 1'b1;
                n_state = S_AGE_CK;
            end
            S_AGE_CK: begin
                o_cmd.ent_age = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_v4    = 1'b1;
                    n_state = S_SW_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_AGE_RD;
                end
            end
            S_SW_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = S_SW_SLOT;
            end
            S_SW_SLOT, S_SW_ENT: begin
                if (r_state == S_SW_SLOT && i_sts.slot_hit) begin
                    o_cmd.ent_rd_slot = 1'b1;
                    n_state = S_SW_ENT;
                end else begin
                    // drop pointers to sessions that just expired
                    o_cmd.slot_zero = (r_state == S_SW_ENT) && !i_sts.ent_valid;
                    if (i_sts.idx_last) begin
                        if (r_v4) begin
                            o_cmd.idx_clr = 1'b1;
                            n_v4    = 1'b0;
                            n_state = S_SW_RD;
                        end else begin
                            n_code  = tst_pkg::RC_TICK;
                            n_state = S_FINISH;
                        end
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_SW_RD;
                    end
                end
            end
            S_FINISH: begin
                if (!r_res_valid || !i_res_stall) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_v4        <= 1'b0;
            r_ins       <= 1'b0;
            r_refresh   <= 1'b0;
            r_code      <= tst_pkg::RC_NF;
            r_res_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_v4      <= n_v4;
            r_ins     <= n_ins;
            r_refresh <= n_refresh;
            r_code    <= n_code;
            if (o_cmd.res_load) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;

    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish state");

endmodule

// ===== hw/rtl/translator_session_table.sv =====
// Top level of the IPv6-to-IPv4 translator session table.
// Find: serial key computation, then one slot probe per probed slot (up to pool size).
// Insert: bitmap clear and entry scan over TABLE_DEPTH, then free-address scan and two probes.
// Tick: an aging pass over the entries, then the two slot sweeps (IPv4 table, then IPv6 table).
// One request at a time, paced by the one-write, one-read slot and entry memories and the serial key unit.
// Reset: synchronous; a clearing pass then empties both tables and the store.
`timescale 1ns / 1ps

module translator_session_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  logic                              i_req_valid,
    output logic                              o_req_stall,
    input  tst_pkg::t_req                     i_req,
    // result channel
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output tst_pkg::t_res                     o_res
);

    // The controller walks the memories through the datapath; the two meet
    // only through the command and status bundles below.
    tst_pkg::t_cmd cmd;
    tst_pkg::t_sts sts;

    // Sequencer: clearing pass after reset, request dispatch, probe loops,
    // insert bitmap build and free search, tick aging and slot sweeps.
    // A request is taken only in idle; the result sits in its own register,
    // so the next request can be taken while that result is still stalled.
    tst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Storage and arithmetic: config registers, the IPv4 and IPv6 slot
    // tables, the entry store (valid bit kept in each entry word), the
    // taken-address bitmap used by inserts, and the serial modulo unit that
    // turns an address into its probe start.
    tst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_res)
    );

endmodule
